// ===== rtl/owsm_pkg.sv =====
// Shared constants and types for the omni wheel speed mixer.
package owsm_pkg;

    localparam int SPEED_W = 7;
    localparam int TURN_W  = 5;
    localparam int MIX_W   = 16;
    localparam int BIAS_W  = 17;
    localparam int PROD_W  = 27;
    localparam int DUTY_W  = 8;
    localparam int WHEELS  = 4;
    localparam int WHEEL_W = $clog2(WHEELS);

    localparam logic signed [MIX_W-1:0]  OBL_Q8  = 16'sd181;
    localparam logic signed [MIX_W-1:0]  FULL_Q8 = 16'sd256;
    localparam logic signed [MIX_W-1:0]  TURN_Q8 = 16'sd320;
    localparam logic signed [BIAS_W-1:0] MID_Q8  = 17'sd9050;
    localparam logic signed [PROD_W-1:0] GAIN_Q8 = 27'sd923;

    localparam logic [7:0] X_LAST     = 8'd99;
    localparam logic [7:0] X_OFFSET   = 8'd50;
    localparam logic [7:0] Y_FIRST    = 8'd101;
    localparam logic [7:0] Y_LAST     = 8'd199;
    localparam logic [7:0] Y_OFFSET   = 8'd150;
    localparam logic [7:0] TURN_FIRST = 8'd220;
    localparam logic [7:0] TURN_LAST  = 8'd240;
    localparam logic [7:0] TURN_BASE  = 8'd230;

    localparam logic LAYOUT_RIGHT   = 1'b0;
    localparam logic LAYOUT_OBLIQUE = 1'b1;

    typedef logic [DUTY_W-1:0] t_duty;

    typedef struct packed {
        t_duty motor3_duty;
        t_duty motor2_duty;
        t_duty motor1_duty;
        t_duty motor0_duty;
    } t_duty_beat;

endpackage

// ===== rtl/omni_wheel_speed_mixer_unit.sv =====
// Omni wheel speed mixer: command decode, layout mix and duty scaling, one wheel at a time.
//
//  channel   | dir | handshake             | payload
//  s (cmd)   | in  | i_s_tvalid/o_s_tready | i_s_tdata[7:0] cmd_byte
//  m (duty)  | out | o_m_tvalid/i_m_tready | o_m_tdata motor0..motor3 duty, 8 bits each
//  cfg       | in  | i_cfg_valid/o_cfg_ready | i_cfg_data wheel_layout
//
// Per wheel, an item passes through a mix state, a multiply state through the shared
// 27-bit multiplier and a saturate state; then a done state loads the output register.
// The next item is accepted only once the unit is back in idle, not while an item is
// in flight. Reset clears speeds, layout and control.
// A stalled output holds its beat; the next item is still accepted, and its result
// waits in the load cycle until the output register frees.
module omni_wheel_speed_mixer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] cmd_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] motor0, [15:8] motor1, [23:16] motor2, [31:24] motor3
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MIX  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SAT  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                                  r_state, n_state;
    logic [owsm_pkg::WHEEL_W-1:0]                r_wheel, n_wheel;
    logic                                        r_layout;
    logic signed [owsm_pkg::SPEED_W-1:0]         r_x, r_y;
    logic signed [owsm_pkg::TURN_W-1:0]          r_turn;
    logic signed [owsm_pkg::MIX_W-1:0]           r_mix;
    logic signed [owsm_pkg::PROD_W-1:0]          r_prod;
    owsm_pkg::t_duty                             r_duty [owsm_pkg::WHEELS];
    logic                                        r_out_valid;
    owsm_pkg::t_duty_beat                        r_out;

    logic                                        w_s_acc;
    logic                                        w_m_acc;
    logic signed [owsm_pkg::MIX_W-1:0]           w_xs, w_ys, w_ts;
    logic signed [owsm_pkg::MIX_W-1:0]           w_xt, w_yt, w_tt, w_wx, w_wy;
    logic signed [owsm_pkg::BIAS_W-1:0]          w_biased;
    owsm_pkg::t_duty                             w_sat;
    logic                                        w_out_free;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_m_acc     = r_out_valid && i_m_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out;

    assign w_xs = owsm_pkg::MIX_W'(r_x);
    assign w_ys = owsm_pkg::MIX_W'(r_y);
    assign w_ts = owsm_pkg::MIX_W'(r_turn);

    always_comb begin
        w_xt = (r_layout == owsm_pkg::LAYOUT_OBLIQUE) ? w_xs * owsm_pkg::OBL_Q8
                                                       : w_xs * owsm_pkg::FULL_Q8;
        w_yt = (r_layout == owsm_pkg::LAYOUT_OBLIQUE) ? w_ys * owsm_pkg::OBL_Q8
                                                       : w_ys * owsm_pkg::FULL_Q8;
        w_tt = w_ts * owsm_pkg::TURN_Q8;
        case (r_wheel)
            2'd0: begin
                w_wx = r_layout ? -w_xt : '0;
                w_wy = w_yt;
            end
            2'd1: begin
                w_wx = -w_xt;
                w_wy = r_layout ? -w_yt : '0;
            end
            2'd2: begin
                w_wx = r_layout ? w_xt : '0;
                w_wy = -w_yt;
            end
            default: begin
                w_wx = w_xt;
                w_wy = r_layout ? w_yt : '0;
            end
        endcase
    end

    assign w_biased = owsm_pkg::BIAS_W'(r_mix) + owsm_pkg::MID_Q8;

    always_comb begin
        if (r_prod[owsm_pkg::PROD_W-1]) begin
            w_sat = '0;
        end else if (|r_prod[owsm_pkg::PROD_W-2:24]) begin
            w_sat = '1;
        end else begin
            w_sat = r_prod[23:16];
        end
    end

    always_comb begin
        n_state = r_state;
        n_wheel = r_wheel;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    n_state = S_MIX;
                    n_wheel = '0;
                end
            end
            S_MIX: n_state = S_MUL;
            S_MUL: n_state = S_SAT;
            S_SAT: begin
                if (r_wheel == owsm_pkg::WHEEL_W'(owsm_pkg::WHEELS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MIX;
                    n_wheel = r_wheel + 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wheel     <= '0;
            r_layout    <= owsm_pkg::LAYOUT_RIGHT;
            r_x         <= '0;
            r_y         <= '0;
            r_turn      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wheel <= n_wheel;
            if (i_cfg_valid && o_cfg_ready) begin
                r_layout <= i_cfg_data;
            end
            if (w_s_acc) begin
                if (i_s_tdata <= owsm_pkg::X_LAST) begin
                    r_x <= owsm_pkg::SPEED_W'(i_s_tdata - owsm_pkg::X_OFFSET);
                end else if (i_s_tdata >= owsm_pkg::Y_FIRST && i_s_tdata <= owsm_pkg::Y_LAST) begin
                    r_y <= owsm_pkg::SPEED_W'(i_s_tdata - owsm_pkg::Y_OFFSET);
                end else if (i_s_tdata >= owsm_pkg::TURN_FIRST
                             && i_s_tdata <= owsm_pkg::TURN_LAST) begin
                    r_turn <= owsm_pkg::TURN_W'(owsm_pkg::TURN_BASE - i_s_tdata);
                end
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (w_m_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MIX) begin
            r_mix <= w_wx + w_wy + w_tt;
        end
        if (r_state == S_MUL) begin
            r_prod <= owsm_pkg::PROD_W'(w_biased) * owsm_pkg::GAIN_Q8;
        end
        if (r_state == S_SAT) begin
            r_duty[r_wheel] <= w_sat;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out.motor0_duty <= r_duty[0];
            r_out.motor1_duty <= r_duty[1];
            r_out.motor2_duty <= r_duty[2];
            r_out.motor3_duty <= r_duty[3];
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> !o_s_tready)
        else $error("item accepted while previous item in flight");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state) == S_DONE)
        else $error("output loaded outside of done state");

    a_last_wheel_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SAT && r_wheel == owsm_pkg::WHEEL_W'(owsm_pkg::WHEELS - 1))
        |=> r_state == S_DONE)
        else $error("sequencer missed done after last wheel");

    a_turn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_turn >= -5'sd10 && r_turn <= 5'sd10)
        else $error("turn speed out of range");

endmodule
